### src/ksm_pkg.sv
// Shared types and codes for the key sequence matcher.
// Holds command, status and operation codes, the queued operation record and
// the state type of the execution unit. No dependencies.
`default_nettype none

package ksm_pkg;

  // Input command codes
  localparam logic [1:0] CMD_WRITE_BYTE = 2'd0;
  localparam logic [1:0] CMD_SET_ENTRY  = 2'd1;
  localparam logic [1:0] CMD_KEY_BYTE   = 2'd2;
  localparam logic [1:0] CMD_TIMEOUT    = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_MATCHED = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE_BYTE,
    OP_SET_ENTRY,
    OP_KEY_BYTE,
    OP_TIMEOUT
  } op_kind_t;

  // One classified item as it travels from the front queue to the back end
  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  entry;
    logic [2:0]  position;
    logic [7:0]  value;
    logic [3:0]  plen;      // already limited to the maximum pattern length
    logic [7:0]  code;
    logic        enable;    // entry is live after a set-entry operation
  } ksm_op_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DRAIN,
    BS_FINISH
  } back_state_t;

endpackage

`default_nettype wire

### src/ksm_front.sv
// Front end of the key sequence matcher: accepts items, classifies them and
// holds them in a two-deep queue for the back end. Depends on ksm_pkg.
`default_nettype none

module ksm_front
  import ksm_pkg::*;
#(
  parameter int MAX_LEN = 8,
  parameter int ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] cmd,
  input  wire logic [3:0] entry,
  input  wire logic [2:0] position,
  input  wire logic [7:0] value,
  input  wire logic [3:0] pattern_len,
  input  wire logic [7:0] entry_code,
  output logic            op_valid,
  input  wire logic       op_ready,
  output ksm_op_t         op
);

  ksm_op_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  ksm_op_t    cls;
  logic       keep;
  logic       push;
  logic       pop;
  logic       entry_ok;
  logic       pos_ok;

  always_comb begin
    entry_ok = 32'(entry) < ENTRIES;
    pos_ok   = 32'(position) < MAX_LEN;

    cls.entry    = entry;
    cls.position = position;
    cls.value    = value;
    cls.code     = entry_code;
    // limit the pattern length to the buffer depth
    if (32'(pattern_len) > MAX_LEN) begin
      cls.plen = 4'(MAX_LEN);
    end else begin
      cls.plen = pattern_len;
    end
    cls.enable = (cls.plen != 4'd0) && (entry_code != 8'd0);

    case (cmd)
      CMD_WRITE_BYTE: begin
        cls.kind = OP_WRITE_BYTE;
        keep     = entry_ok && pos_ok;
      end
      CMD_SET_ENTRY: begin
        cls.kind = OP_SET_ENTRY;
        keep     = entry_ok;
      end
      CMD_KEY_BYTE: begin
        cls.kind = OP_KEY_BYTE;
        keep     = 1'b1;
      end
      CMD_TIMEOUT: begin
        cls.kind = OP_TIMEOUT;
        keep     = 1'b1;
      end
      default: begin
        cls.kind = OP_TIMEOUT;
        keep     = 1'b1;
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];
  // drop out-of-range load items here; they change nothing
  assign push     = in_valid && in_ready && keep;
  assign pop      = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("front queue count out of range");

  assert property (@(posedge clk) disable iff (rst)
                   (push && !pop) |=> (count != 2'd0))
    else $error("pushed item lost from front queue");

  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("full queue pointers disagree");

endmodule

`default_nettype wire

### src/ksm_back.sv
// Back end of the key sequence matcher: pattern table memories, sequence
// buffer, entry-by-entry scan and the output register. Depends on ksm_pkg.
`default_nettype none

module ksm_back
  import ksm_pkg::*;
#(
  parameter int MAX_LEN = 8,
  parameter int ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       op_valid,
  output logic            op_ready,
  input  wire ksm_op_t    op,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [7:0]      key_code
);

  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLW = $clog2(MAX_LEN + 1);
  localparam int PW  = $clog2(MAX_LEN);

  // table storage
  logic [MAX_LEN-1:0][7:0] pat_mem  [ENTRIES];
  logic [SLW-1:0]          len_mem  [ENTRIES];
  logic [7:0]              code_mem [ENTRIES];
  logic [ENTRIES-1:0]      entry_vld;

  // sequence buffer
  logic [7:0]     seq_buf [MAX_LEN];
  logic [SLW-1:0] seq_len;

  // scan pipeline
  back_state_t             state;
  back_state_t             state_next;
  logic [EW-1:0]           rd_idx;
  logic [MAX_LEN-1:0][7:0] rd_row;
  logic [SLW-1:0]          rd_len;
  logic [7:0]              rd_code;
  logic                    rd_vld;
  logic                    cmp_valid;
  logic                    hit_found;
  logic [7:0]              hit_code;
  logic                    prefix_found;

  logic           slot_free;
  logic           emit;
  logic [1:0]     emit_status;
  logic [7:0]     emit_code;
  logic           do_write;
  logic           do_set;
  logic           do_append;
  logic           row_eq;
  logic           exact;
  logic           prefix;
  logic [EW-1:0]  wr_idx;

  assign slot_free = !out_valid || out_ready;
  assign wr_idx    = EW'(op.entry);

  always_comb begin
    row_eq = 1'b1;
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((SLW'(i) < seq_len) && (rd_row[i] != seq_buf[i])) begin
        row_eq = 1'b0;
      end
    end
    exact  = rd_vld && row_eq && (rd_len == seq_len);
    prefix = rd_vld && row_eq && (rd_len > seq_len);
  end

  always_comb begin
    state_next  = state;
    op_ready    = 1'b0;
    emit        = 1'b0;
    emit_status = STATUS_UNKNOWN;
    emit_code   = 8'd0;
    do_write    = 1'b0;
    do_set      = 1'b0;
    do_append   = 1'b0;
    case (state)
      BS_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            OP_WRITE_BYTE: begin
              op_ready = 1'b1;
              do_write = 1'b1;
            end
            OP_SET_ENTRY: begin
              op_ready = 1'b1;
              do_set   = 1'b1;
            end
            OP_TIMEOUT: begin
              if (slot_free) begin
                op_ready    = 1'b1;
                emit        = 1'b1;
                emit_status = STATUS_TIMEOUT;
              end
            end
            OP_KEY_BYTE: begin
              if (seq_len >= SLW'(MAX_LEN)) begin
                // buffer already full: report unknown
                if (slot_free) begin
                  op_ready    = 1'b1;
                  emit        = 1'b1;
                  emit_status = STATUS_UNKNOWN;
                end
              end else begin
                op_ready   = 1'b1;
                do_append  = 1'b1;
                state_next = BS_SCAN;
              end
            end
            default: begin
              op_ready = 1'b1;
            end
          endcase
        end
      end
      BS_SCAN: begin
        if (rd_idx == EW'(ENTRIES - 1)) begin
          state_next = BS_DRAIN;
        end
      end
      BS_DRAIN: begin
        state_next = BS_FINISH;
      end
      BS_FINISH: begin
        if (hit_found) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = STATUS_MATCHED;
            emit_code   = hit_code;
            state_next  = BS_IDLE;
          end
        end else if (!prefix_found) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = STATUS_UNKNOWN;
            state_next  = BS_IDLE;
          end
        end else begin
          // still a live prefix: wait for more bytes
          state_next = BS_IDLE;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  // table memories and registered reads
  always_ff @(posedge clk) begin
    if (do_write) begin
      pat_mem[wr_idx][PW'(op.position)] <= op.value;
    end
    if (do_set) begin
      len_mem[wr_idx]  <= SLW'(op.plen);
      code_mem[wr_idx] <= op.code;
    end
    rd_row  <= pat_mem[rd_idx];
    rd_len  <= len_mem[rd_idx];
    rd_code <= code_mem[rd_idx];
    rd_vld  <= entry_vld[rd_idx];
    if (do_append) begin
      seq_buf[seq_len[PW-1:0]] <= op.value;
    end
    if (emit) begin
      status   <= emit_status;
      key_code <= emit_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BS_IDLE;
      entry_vld    <= '0;
      seq_len      <= '0;
      rd_idx       <= '0;
      cmp_valid    <= 1'b0;
      hit_found    <= 1'b0;
      hit_code     <= 8'd0;
      prefix_found <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == BS_SCAN);
      if (do_set) begin
        entry_vld[wr_idx] <= op.enable;
      end
      if (do_append) begin
        seq_len      <= seq_len + SLW'(1);
        rd_idx       <= '0;
        hit_found    <= 1'b0;
        prefix_found <= 1'b0;
      end else if (state == BS_SCAN) begin
        rd_idx <= rd_idx + EW'(1);
      end
      if (cmp_valid) begin
        // lowest entry wins: keep the first exact hit
        if (exact && !hit_found) begin
          hit_found <= 1'b1;
          hit_code  <= rd_code;
        end
        if (prefix) begin
          prefix_found <= 1'b1;
        end
      end
      if (emit) begin
        seq_len   <= '0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) seq_len <= SLW'(MAX_LEN))
    else $error("sequence length beyond buffer depth");

  assert property (@(posedge clk) disable iff (rst) emit |=> (seq_len == '0))
    else $error("buffer not cleared after a result");

  assert property (@(posedge clk) disable iff (rst)
                   (state == BS_DRAIN) |-> ($past(state) == BS_SCAN))
    else $error("drain entered without a scan");

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && (status != STATUS_MATCHED)) |-> (key_code == 8'd0))
    else $error("key code set on a non-match result");

endmodule

`default_nettype wire

### src/key_sequence_matcher.sv
// Key sequence matcher top level: front classifier queue and back end.
// Depends on ksm_pkg, ksm_front and ksm_back.
//
// Usage: one input channel (in_valid/in_ready) carries load items that fill
// the pattern table, key bytes and timeouts. One output channel
// (out_valid/out_ready) carries status and key_code results.
// Load items and out-of-range loads give no result; a timeout always gives
// one; a key byte gives a match, an unknown, or nothing while the buffer is
// still a prefix of some live entry.
// A load passes through the queue and then the table write.
// A key byte scans one table entry per cycle through the pattern memory
// read port before its result is registered; a timeout or a full-buffer
// byte reports its result without a scan.
// The back end takes no new item until the scan of a key byte is done.
// The two-deep queue keeps taking items, up to two, while the back end works.
// Reset clears the queue, the entry valid flags and the sequence length;
// pattern contents stay undefined until written.
// If the receiver stalls, the result is held in the output register and
// the back end waits before it produces another result.
`default_nettype none

module key_sequence_matcher
  import ksm_pkg::*;
#(
  parameter int MAX_LEN = 8,
  parameter int ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] cmd,
  input  wire logic [3:0] entry,
  input  wire logic [2:0] position,
  input  wire logic [7:0] value,
  input  wire logic [3:0] pattern_len,
  input  wire logic [7:0] entry_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [7:0]      key_code
);

  logic    op_valid;
  logic    op_ready;
  ksm_op_t op;

  ksm_front #(
    .MAX_LEN (MAX_LEN),
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entry       (entry),
    .position    (position),
    .value       (value),
    .pattern_len (pattern_len),
    .entry_code  (entry_code),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op)
  );

  ksm_back #(
    .MAX_LEN (MAX_LEN),
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .key_code  (key_code)
  );

endmodule

`default_nettype wire
